// ===== rtl/scm_pkg.sv =====
`default_nettype none

package scm_pkg;

	localparam int ROW_W       = 8;
	localparam int VAL_W       = 32;
	localparam int DIM_W       = 9;
	localparam int STAT_W      = 3;
	localparam int ACT_W       = 2;
	localparam int REG_W       = 1;
	localparam int DATA_W      = 48;
	localparam int USER_IN_W   = 3;
	localparam int MAX_RESULTS = 32;
	localparam int NW          = $clog2(MAX_RESULTS + 1);

	localparam logic [DIM_W-1:0] ROW_COUNT_RESET = 9'd8;
	localparam logic [DIM_W-1:0] COL_COUNT_RESET = 9'd9;

	localparam logic [REG_W-1:0] REG_ROW_COUNT = 1'b0;
	localparam logic [REG_W-1:0] REG_COL_COUNT = 1'b1;

	typedef enum logic [ACT_W-1:0] {
		ACT_SET = 2'd0,
		ACT_GET = 2'd1,
		ACT_ADD = 2'd2
	} act_t;

	typedef enum logic [STAT_W-1:0] {
		STS_INSERTED = 3'd0,
		STS_UPDATED  = 3'd1,
		STS_OOR      = 3'd2,
		STS_FULL     = 3'd3,
		STS_HIT      = 3'd4,
		STS_MISS     = 3'd5,
		STS_SUM      = 3'd6,
		STS_EMPTY    = 3'd7
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE,
		S_FLUSH
	} state_t;

	typedef struct packed {
		logic clear;
		logic cmp;
		logic add_mode;
	} cmd_t;

	typedef struct packed {
		logic match;
		logic found;
		logic hit;
	} flags_t;

endpackage

`default_nettype wire

// ===== rtl/sparse_coo_store_merge_add.sv =====
// Set and get scan the item's bank, stopping on a match; an out-of-range set does not scan.
// Add: each output coordinate costs one pass over both banks, plus one closing pass
// unless the result limit ends the add; at most 32 results per add.
// One item is in work at a time; the scan through the entry RAM sets the rate.
// Reset clears entry counts, output valid and sequencer state; dimension registers go to 8 and 9.
`default_nettype none

module sparse_coo_store_merge_add #(
	parameter int CAPACITY   = 16,
	parameter int COORD_BITS = 8
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// row[7:0], col[15:8], value[47:16]
	input  wire logic [scm_pkg::DATA_W-1:0]      s_tdata,
	// action[1:0], bank[2]
	input  wire logic [scm_pkg::USER_IN_W-1:0]   s_tuser,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// out_row[7:0], out_col[15:8], out_value[47:16]
	output logic      [scm_pkg::DATA_W-1:0]      m_tdata,
	// status[2:0]
	output logic      [scm_pkg::STAT_W-1:0]      m_tuser,
	output logic                                 m_tlast,
	input  wire logic                            cfg_we,
	input  wire logic [scm_pkg::REG_W-1:0]       cfg_addr,
	input  wire logic [scm_pkg::DIM_W-1:0]       cfg_wdata
);

	import scm_pkg::*;

	localparam int CW    = (COORD_BITS < ROW_W) ? COORD_BITS : ROW_W;
	localparam int IW    = $clog2(CAPACITY + 1);
	localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int EW    = 2 * CW + VAL_W;
	localparam int DEPTH = 2 << AW;

	state_t           state_q, state_d;
	logic [DIM_W-1:0] row_count_q, col_count_q;
	logic [IW-1:0]    cnt_q [2];

	act_t             act_q;
	logic             bank_q;
	logic [CW-1:0]    row_q, col_q;
	logic [VAL_W-1:0] val_q;
	logic             oor_q;

	logic             ibank_q;
	logic [IW-1:0]    idx_q;
	logic             issued_q;
	logic             rvld_q;
	logic [AW-1:0]    chk_q;
	logic             have_prev_q;
	logic [NW-1:0]    n_q;
	logic [2*CW-1:0]  prev_q;
	logic [VAL_W-1:0] psum_q;

	logic             m_tvalid_q;
	status_t          status_q;
	logic [ROW_W-1:0] orow_q, ocol_q;
	logic [VAL_W-1:0] oval_q;
	logic             olast_q;

	act_t             in_act;
	logic             in_bank;
	logic [CW-1:0]    in_row, in_col;
	logic [VAL_W-1:0] in_val;
	logic             in_oor;
	logic             accept;
	logic             add_mode;
	logic             bank_end;
	logic             out_free;
	logic             last_slot;

	cmd_t             cmd;
	flags_t           flags;
	logic             rd_en;
	logic [AW:0]      rd_addr;
	logic [EW-1:0]    rd_data;
	logic             wr_en;
	logic [AW:0]      wr_addr;
	logic [EW-1:0]    wr_data;
	logic             do_insert;
	logic [2*CW-1:0]  best_key;
	logic [VAL_W-1:0] sum;
	logic [VAL_W-1:0] hit_val;
	logic [AW-1:0]    hit_idx;

	logic             load;
	status_t          o_status;
	logic [ROW_W-1:0] o_row, o_col;
	logic [VAL_W-1:0] o_val;
	logic             o_last;

	assign in_act   = act_t'(s_tuser[ACT_W-1:0]);
	assign in_bank  = s_tuser[ACT_W];
	assign in_row   = s_tdata[CW-1:0];
	assign in_col   = s_tdata[ROW_W +: CW];
	assign in_val   = s_tdata[2*ROW_W +: VAL_W];
	assign in_oor   = (DIM_W'(in_row) >= row_count_q) || (DIM_W'(in_col) >= col_count_q);

	assign s_tready  = (state_q == S_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign add_mode  = (act_q == ACT_ADD);
	assign bank_end  = (idx_q == cnt_q[ibank_q]);
	assign out_free  = !m_tvalid_q || m_tready;
	assign last_slot = (n_q == NW'(MAX_RESULTS - 1));
	assign rd_addr   = {ibank_q, idx_q[AW-1:0]};

	scm_ram #(
		.WIDTH(EW),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	scm_alu #(
		.CW(CW),
		.AW(AW)
	) u_alu (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.rd_row   (rd_data[CW-1:0]),
		.rd_col   (rd_data[CW +: CW]),
		.rd_val   (rd_data[2*CW +: VAL_W]),
		.rd_idx   (chk_q),
		.key_row  (row_q),
		.key_col  (col_q),
		.prev_key (prev_q),
		.have_prev(have_prev_q),
		.flags    (flags),
		.best_key (best_key),
		.sum      (sum),
		.hit_val  (hit_val),
		.hit_idx  (hit_idx)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (in_act)
						ACT_SET: state_d = in_oor ? S_DONE : S_SCAN;
						ACT_GET: state_d = S_SCAN;
						ACT_ADD: state_d = S_SCAN;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_SCAN: begin
				if (flags.match || (issued_q && !rvld_q)) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					if (add_mode && flags.found) begin
						state_d = (have_prev_q && last_slot) ? S_FLUSH : S_SCAN;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_FLUSH: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		rd_en     = 1'b0;
		wr_en     = 1'b0;
		wr_addr   = {bank_q, hit_idx};
		wr_data   = {val_q, col_q, row_q};
		do_insert = 1'b0;
		load      = 1'b0;
		o_status  = STS_SUM;
		o_row     = ROW_W'(row_q);
		o_col     = ROW_W'(col_q);
		o_val     = val_q;
		o_last    = 1'b1;
		case (state_q)
			S_IDLE: begin
				cmd.clear = 1'b1;
			end
			S_SCAN: begin
				cmd.cmp      = rvld_q;
				cmd.add_mode = add_mode;
				rd_en        = !issued_q && !bank_end;
			end
			S_DONE: begin
				if (out_free) begin
					case (act_q)
						ACT_SET: begin
							load = 1'b1;
							if (oor_q) begin
								o_status = STS_OOR;
							end else if (flags.hit) begin
								wr_en    = 1'b1;
								o_status = STS_UPDATED;
							end else if (cnt_q[bank_q] >= IW'(CAPACITY)) begin
								o_status = STS_FULL;
							end else begin
								wr_en     = 1'b1;
								do_insert = 1'b1;
								wr_addr   = {bank_q, cnt_q[bank_q][AW-1:0]};
								o_status  = STS_INSERTED;
							end
						end
						ACT_GET: begin
							load = 1'b1;
							if (flags.hit) begin
								o_status = STS_HIT;
								o_val    = hit_val;
							end else begin
								o_status = STS_MISS;
								o_val    = '0;
							end
						end
						ACT_ADD: begin
							cmd.clear = flags.found;
							o_row     = ROW_W'(prev_q[2*CW-1:CW]);
							o_col     = ROW_W'(prev_q[CW-1:0]);
							o_val     = psum_q;
							if (flags.found) begin
								load   = have_prev_q;
								o_last = 1'b0;
							end else if (have_prev_q) begin
								load = 1'b1;
							end else begin
								load     = 1'b1;
								o_status = STS_EMPTY;
								o_row    = '0;
								o_col    = '0;
								o_val    = '0;
							end
						end
						default: begin
							load = 1'b0;
						end
					endcase
				end
			end
			S_FLUSH: begin
				load  = out_free;
				o_row = ROW_W'(prev_q[2*CW-1:CW]);
				o_col = ROW_W'(prev_q[CW-1:0]);
				o_val = psum_q;
			end
			default: begin
				cmd.clear = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			row_count_q <= ROW_COUNT_RESET;
			col_count_q <= COL_COUNT_RESET;
			cnt_q[0]    <= '0;
			cnt_q[1]    <= '0;
			ibank_q     <= 1'b0;
			idx_q       <= '0;
			issued_q    <= 1'b0;
			rvld_q      <= 1'b0;
			have_prev_q <= 1'b0;
			n_q         <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_addr)
					REG_ROW_COUNT: row_count_q <= cfg_wdata;
					REG_COL_COUNT: col_count_q <= cfg_wdata;
					default:       row_count_q <= row_count_q;
				endcase
			end
			if (load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (do_insert) begin
				cnt_q[bank_q] <= cnt_q[bank_q] + IW'(1);
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						ibank_q     <= (in_act == ACT_ADD) ? 1'b0 : in_bank;
						idx_q       <= '0;
						issued_q    <= 1'b0;
						rvld_q      <= 1'b0;
						have_prev_q <= 1'b0;
						n_q         <= '0;
					end
				end
				S_SCAN: begin
					rvld_q <= rd_en;
					if (!issued_q) begin
						if (bank_end) begin
							if (add_mode && !ibank_q) begin
								ibank_q <= 1'b1;
								idx_q   <= '0;
							end else begin
								issued_q <= 1'b1;
							end
						end else begin
							idx_q <= idx_q + IW'(1);
						end
					end
				end
				S_DONE: begin
					if (out_free && add_mode && flags.found) begin
						have_prev_q <= 1'b1;
						n_q         <= n_q + NW'(1);
						ibank_q     <= 1'b0;
						idx_q       <= '0;
						issued_q    <= 1'b0;
						rvld_q      <= 1'b0;
					end
				end
				default: begin
					rvld_q <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q  <= in_act;
			bank_q <= in_bank;
			row_q  <= in_row;
			col_q  <= in_col;
			val_q  <= in_val;
			oor_q  <= in_oor;
		end
		if (rd_en) begin
			chk_q <= idx_q[AW-1:0];
		end
		if ((state_q == S_DONE) && out_free && add_mode && flags.found) begin
			prev_q <= best_key;
			psum_q <= sum;
		end
		if (load) begin
			status_q <= o_status;
			orow_q   <= o_row;
			ocol_q   <= o_col;
			oval_q   <= o_val;
			olast_q  <= o_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {oval_q, ocol_q, orow_q};
	assign m_tuser  = status_q;
	assign m_tlast  = olast_q;

endmodule

`default_nettype wire

// ===== rtl/scm_ram.sv =====
`default_nettype none

module scm_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/scm_alu.sv =====
`default_nettype none

module scm_alu #(
	parameter int CW = 8,
	parameter int AW = 4
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire scm_pkg::cmd_t               cmd,
	input  wire logic [CW-1:0]               rd_row,
	input  wire logic [CW-1:0]               rd_col,
	input  wire logic [scm_pkg::VAL_W-1:0]   rd_val,
	input  wire logic [AW-1:0]               rd_idx,
	input  wire logic [CW-1:0]               key_row,
	input  wire logic [CW-1:0]               key_col,
	input  wire logic [2*CW-1:0]             prev_key,
	input  wire logic                        have_prev,
	output scm_pkg::flags_t                  flags,
	output logic      [2*CW-1:0]             best_key,
	output logic      [scm_pkg::VAL_W-1:0]   sum,
	output logic      [scm_pkg::VAL_W-1:0]   hit_val,
	output logic      [AW-1:0]               hit_idx
);

	import scm_pkg::*;

	logic [2*CW-1:0]  key;
	logic             match;
	logic             elig;
	logic             take;
	logic             same;
	logic             found_q;
	logic             hit_q;
	logic [2*CW-1:0]  best_q;
	logic [VAL_W-1:0] sum_q;
	logic [VAL_W-1:0] hit_val_q;
	logic [AW-1:0]    hit_idx_q;

	assign key   = {rd_row, rd_col};
	assign match = cmd.cmp && !cmd.add_mode && (rd_row == key_row) && (rd_col == key_col);
	assign elig  = cmd.cmp && cmd.add_mode && (!have_prev || (key > prev_key));
	assign take  = elig && (!found_q || (key < best_q));
	assign same  = elig && found_q && (key == best_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			hit_q   <= 1'b0;
		end else if (cmd.clear) begin
			found_q <= 1'b0;
			hit_q   <= 1'b0;
		end else begin
			if (take) begin
				found_q <= 1'b1;
			end
			if (match) begin
				hit_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_q <= key;
			sum_q  <= rd_val;
		end else if (same) begin
			sum_q <= sum_q + rd_val;
		end
		if (match) begin
			hit_val_q <= rd_val;
			hit_idx_q <= rd_idx;
		end
	end

	assign flags.match = match;
	assign flags.found = found_q;
	assign flags.hit   = hit_q;
	assign best_key    = best_q;
	assign sum         = sum_q;
	assign hit_val     = hit_val_q;
	assign hit_idx     = hit_idx_q;

endmodule

`default_nettype wire

// ===== rtl/scm_checker.sv =====
`default_nettype none

module scm_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          s_tvalid,
	input wire logic                          s_tready,
	input wire logic [scm_pkg::USER_IN_W-1:0] s_tuser,
	input wire logic                          m_tvalid,
	input wire logic                          m_tready,
	input wire logic [scm_pkg::DATA_W-1:0]    m_tdata,
	input wire logic [scm_pkg::STAT_W-1:0]    m_tuser,
	input wire logic                          m_tlast
);

	import scm_pkg::*;

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("output transaction changed while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser[ACT_W-1:0] == ACT_SET
			|| s_tuser[ACT_W-1:0] == ACT_GET || s_tuser[ACT_W-1:0] == ACT_ADD)
		|=> !s_tready)
		else $error("input accepted while an item is in work");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == STS_EMPTY |-> m_tlast && m_tdata == '0)
		else $error("empty sum result malformed");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == STS_INSERTED || m_tuser == STS_UPDATED
			|| m_tuser == STS_OOR || m_tuser == STS_FULL
			|| m_tuser == STS_HIT || m_tuser == STS_MISS)
		|-> m_tlast)
		else $error("single result without last");

endmodule

bind sparse_coo_store_merge_add scm_checker u_scm_checker (.*);

`default_nettype wire
